// ===== sv/clock_buffer_frame_manager_unit_macros.svh =====
// Assertion macros shared by the checker of the frame manager.
`ifndef CLOCK_BUFFER_FRAME_MANAGER_UNIT_MACROS_SVH
`define CLOCK_BUFFER_FRAME_MANAGER_UNIT_MACROS_SVH
// Same-cycle implication, sampled on the clock and held off during reset.
`define CBFM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on the clock and held off during reset.
`define CBFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== sv/cbfm_pkg.sv =====
// Package with the types, codes and defaults of the frame manager.
package cbfm_pkg;
	localparam int FRAMES_DEF    = 16;
	localparam int PIN_WIDTH_DEF = 16;
	localparam int FRAME_W       = 4;

	typedef enum logic [2:0] {
		REQ_READ    = 3'd0,
		REQ_ALLOC   = 3'd1,
		REQ_UNPIN   = 3'd2,
		REQ_DISPOSE = 3'd3,
		REQ_FLUSH   = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ALL_PINNED = 2'd1,
		ST_NOT_PINNED = 2'd2,
		ST_PINNED     = 2'd3
	} status_t;

	typedef struct packed {
		logic pin_en;
		logic tag_en;
	} cbfm_wr_t;
endpackage

// ===== sv/cbfm_store.sv =====
// Tag and pin count memory of the frame table, one access per cycle.
module cbfm_store #(
	parameter int FRAMES    = cbfm_pkg::FRAMES_DEF,
	parameter int PIN_WIDTH = cbfm_pkg::PIN_WIDTH_DEF,
	parameter int IW        = $clog2(FRAMES)
) (
	input  logic                 clk,
	input  logic [IW-1:0]        idx,
	input  cbfm_pkg::cbfm_wr_t   wr,
	input  logic [PIN_WIDTH-1:0] wr_pin,
	input  logic [15:0]          wr_file,
	input  logic [31:0]          wr_page,
	output logic [PIN_WIDTH-1:0] rd_pin,
	output logic [15:0]          rd_file,
	output logic [31:0]          rd_page
);
	import cbfm_pkg::*;

	logic [PIN_WIDTH-1:0] pin_mem [FRAMES];
	logic [47:0]          tag_mem [FRAMES];
	logic [47:0]          tag_q;

	always_ff @(posedge clk) begin
		if (wr.pin_en) begin
			pin_mem[idx] <= wr_pin;
		end
		if (wr.tag_en) begin
			tag_mem[idx] <= {wr_file, wr_page};
		end
		rd_pin <= pin_mem[idx];
		tag_q  <= tag_mem[idx];
	end

	assign rd_file = tag_q[47:32];
	assign rd_page = tag_q[31:0];
endmodule

// ===== sv/clock_buffer_frame_manager_unit.sv =====
// Top level of the clock-replacement frame manager: sequencer and frame flags.
// Requests are served one at a time; in_ready is high only while idle. A small
// sequencer walks the frame table through one shared tag and pin memory port,
// visiting each frame with an address state, then a compare and update state,
// and handing the final beat to the output register from an emit state. A lookup
// visits up to FRAMES frames; a read miss then sweeps the clock hand, as an alloc
// does at once, which may take up to two laps. Flush emits one beat per dirty
// frame of the file and waits there while the output is stalled, then a last beat;
// a pinned frame of the file ends it early. No clearing pass follows reset.
module clock_buffer_frame_manager_unit #(
	parameter int FRAMES    = cbfm_pkg::FRAMES_DEF,
	parameter int PIN_WIDTH = cbfm_pkg::PIN_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [15:0] file_id,
	input  logic [31:0] page_no,
	input  logic        dirty_mark,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  frame,
	output logic        hit,
	output logic        writeback,
	output logic [15:0] wb_file,
	output logic [31:0] wb_page,
	output logic [1:0]  status,
	output logic        last
);
	import cbfm_pkg::*;

	localparam int IW = $clog2(FRAMES);
	localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);
	localparam logic [PIN_WIDTH-1:0] PIN_MAX = '1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ADDR = 4'b0010,
		S_EVAL = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [2:0]  op_q, op_d;
	logic [15:0] file_q, file_d;
	logic [31:0] page_q, page_d;
	logic        dm_q, dm_d, sweep_q, sweep_d;
	logic [IW-1:0] idx_q, idx_d, hand_q, hand_d, pcnt_q, pcnt_d, hand_nxt;
	logic [FRAMES-1:0] valid_q, valid_d, ref_q, ref_d, dirty_q, dirty_d;
	logic [3:0]  pf_q, pf_d;
	logic        ph_q, ph_d, pw_q, pw_d;
	logic [15:0] pwf_q, pwf_d;
	logic [31:0] pwp_q, pwp_d;
	logic [1:0]  pst_q, pst_d;
	logic        ovalid_q, emit_mid, emit_fin, can_emit;
	logic [3:0]  of_q;
	logic        oh_q, ow_q, ol_q;
	logic [15:0] owf_q;
	logic [31:0] owp_q;
	logic [1:0]  ost_q;
	cbfm_wr_t wr;
	logic [PIN_WIDTH-1:0] wr_pin, rd_pin;
	logic [15:0] rd_file;
	logic [31:0] rd_page;
	logic fmatch, match, pinned;

	cbfm_store #(.FRAMES(FRAMES), .PIN_WIDTH(PIN_WIDTH), .IW(IW)) u_store (
		.clk(clk), .idx(idx_q), .wr(wr), .wr_pin(wr_pin), .wr_file(file_q),
		.wr_page(page_q), .rd_pin(rd_pin), .rd_file(rd_file), .rd_page(rd_page)
	);

	assign hand_nxt = (hand_q == LAST_IDX) ? '0 : hand_q + 1'b1;
	assign fmatch   = valid_q[idx_q] && (rd_file == file_q);
	assign match    = fmatch && (rd_page == page_q);
	assign pinned   = (rd_pin != '0);
	assign can_emit = !ovalid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q; op_d = op_q; file_d = file_q; page_d = page_q; dm_d = dm_q;
		sweep_d = sweep_q; idx_d = idx_q; hand_d = hand_q; pcnt_d = pcnt_q;
		valid_d = valid_q; ref_d = ref_q; dirty_d = dirty_q;
		pf_d = pf_q; ph_d = ph_q; pw_d = pw_q; pwf_d = pwf_q; pwp_d = pwp_q; pst_d = pst_q;
		wr = '0; wr_pin = '0; emit_mid = 1'b0; emit_fin = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d = req_type; file_d = file_id; page_d = page_no; dm_d = dirty_mark;
					pf_d = '0; ph_d = 1'b0; pw_d = 1'b0; pwf_d = '0; pwp_d = '0;
					pst_d = ST_OK; sweep_d = 1'b0; pcnt_d = '0; idx_d = '0;
					state_d = S_ADDR;
					if (req_type == REQ_ALLOC) begin
						sweep_d = 1'b1; hand_d = hand_nxt; idx_d = hand_nxt;
					end else if (req_type > REQ_FLUSH) begin
						state_d = S_EMIT;
					end
				end
			end
			S_ADDR: state_d = S_EVAL;
			S_EVAL: begin
				state_d = S_ADDR;
				if (sweep_q) begin
					if (valid_q[idx_q] && ref_q[idx_q]) begin
						ref_d[idx_q] = 1'b0; hand_d = hand_nxt; idx_d = hand_nxt;
					end else if (valid_q[idx_q] && pinned) begin
						if (pcnt_q == LAST_IDX) begin
							pst_d = ST_ALL_PINNED; state_d = S_EMIT;
						end else begin
							pcnt_d = pcnt_q + 1'b1; hand_d = hand_nxt; idx_d = hand_nxt;
						end
					end else begin
						if (valid_q[idx_q] && dirty_q[idx_q]) begin
							pw_d = 1'b1; pwf_d = rd_file; pwp_d = rd_page;
						end
						valid_d[idx_q] = 1'b1; ref_d[idx_q] = 1'b1; dirty_d[idx_q] = 1'b0;
						wr = '{pin_en: 1'b1, tag_en: 1'b1}; wr_pin = PIN_WIDTH'(1);
						pf_d = 4'(idx_q); state_d = S_EMIT;
					end
				end else if (op_q == REQ_FLUSH) begin
					if (fmatch && pinned) begin
						pf_d = 4'(idx_q); pst_d = ST_PINNED; state_d = S_EMIT;
					end else if (fmatch && dirty_q[idx_q] && !can_emit) begin
						state_d = S_EVAL;
					end else begin
						if (fmatch) begin
							emit_mid = dirty_q[idx_q];
							valid_d[idx_q] = 1'b0; ref_d[idx_q] = 1'b0; dirty_d[idx_q] = 1'b0;
						end
						if (idx_q == LAST_IDX) state_d = S_EMIT;
						else idx_d = idx_q + 1'b1;
					end
				end else if (match) begin
					pf_d = 4'(idx_q); ph_d = 1'b1; state_d = S_EMIT;
					case (op_q)
						REQ_READ: begin
							ref_d[idx_q] = 1'b1; wr.pin_en = 1'b1;
							wr_pin = (rd_pin == PIN_MAX) ? rd_pin : rd_pin + 1'b1;
						end
						REQ_UNPIN: begin
							if (!pinned) begin
								pst_d = ST_NOT_PINNED;
							end else begin
								wr.pin_en = 1'b1; wr_pin = rd_pin - 1'b1;
								dirty_d[idx_q] = dirty_q[idx_q] | dm_q;
							end
						end
						default: begin
							valid_d[idx_q] = 1'b0; ref_d[idx_q] = 1'b0; dirty_d[idx_q] = 1'b0;
						end
					endcase
				end else if (idx_q == LAST_IDX) begin
					if (op_q == REQ_READ) begin
						sweep_d = 1'b1; hand_d = hand_nxt; idx_d = hand_nxt;
					end else begin
						state_d = S_EMIT;
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_EMIT: begin
				if (can_emit) begin
					emit_fin = 1'b1; state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; sweep_q <= 1'b0; hand_q <= LAST_IDX; pcnt_q <= '0;
			idx_q <= '0; valid_q <= '0; ref_q <= '0; dirty_q <= '0; ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d; sweep_q <= sweep_d; hand_q <= hand_d; pcnt_q <= pcnt_d;
			idx_q <= idx_d; valid_q <= valid_d; ref_q <= ref_d; dirty_q <= dirty_d;
			if (emit_mid || emit_fin) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d; file_q <= file_d; page_q <= page_d; dm_q <= dm_d;
		pf_q <= pf_d; ph_q <= ph_d; pw_q <= pw_d; pwf_q <= pwf_d; pwp_q <= pwp_d;
		pst_q <= pst_d;
		if (emit_mid) begin
			of_q <= 4'(idx_q); oh_q <= 1'b0; ow_q <= 1'b1; owf_q <= rd_file;
			owp_q <= rd_page; ost_q <= ST_OK; ol_q <= 1'b0;
		end else if (emit_fin) begin
			of_q <= pf_q; oh_q <= ph_q; ow_q <= pw_q; owf_q <= pwf_q;
			owp_q <= pwp_q; ost_q <= pst_q; ol_q <= 1'b1;
		end
	end

	assign out_valid = ovalid_q;
	assign frame     = of_q;
	assign hit       = oh_q;
	assign writeback = ow_q;
	assign wb_file   = owf_q;
	assign wb_page   = owp_q;
	assign status    = ost_q;
	assign last      = ol_q;
endmodule

// ===== sv/cbfm_checker.sv =====
// Port-level checker of the frame manager and its bind to the top level.
`include "clock_buffer_frame_manager_unit_macros.svh"
module cbfm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] frame,
	input logic       hit,
	input logic       writeback,
	input logic [1:0] status,
	input logic       last
);
	import cbfm_pkg::*;

	`CBFM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame), "Stalled beat changed.")
	`CBFM_ASSERT_NOW(a_fail_form, out_valid && status == ST_ALL_PINNED, frame == 4'd0 && last && !writeback, "Bad all-pinned beat.")
	`CBFM_ASSERT_NOW(a_hit_clean, out_valid && hit, !writeback && status != ST_ALL_PINNED, "Hit beat with victim fields.")
	`CBFM_ASSERT_NOW(a_wb_ok, out_valid && writeback, status == ST_OK && !hit, "Writeback beat with bad status.")
endmodule

bind clock_buffer_frame_manager_unit cbfm_checker u_cbfm_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.frame(frame), .hit(hit), .writeback(writeback), .status(status), .last(last)
);
